FILE: hw/rtl/ebt_pkg.sv
package ebt_pkg;

    // Field widths
    localparam int TIME_W   = 48;
    localparam int COUNT_W  = 16;
    localparam int MS_W     = 16;
    localparam int RND_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    // Scheme constants
    localparam int POWER_BASE   = 2;
    localparam int TICKS_PER_MS = 10000;

    localparam int BASE_W     = $clog2(POWER_BASE + 1);
    localparam int TICKS_W    = $clog2(TICKS_PER_MS + 1);
    localparam int JITTER_W   = MS_W + TICKS_W;
    localparam int PROD_W     = TIME_W + BASE_W;
    localparam int DIV_CNT_W  = $clog2(RND_W);

    // Register reset values
    localparam logic [COUNT_W-1:0] MAX_RETRY_RST   = '0;
    localparam logic [TIME_W-1:0]  MAX_WAIT_RST    = TIME_W'(100000000);
    localparam logic [TIME_W-1:0]  FACTOR_RST      = TIME_W'(3000000);
    localparam logic [TIME_W-1:0]  MIN_IDLE_RST    = TIME_W'(400000000);
    localparam logic [MS_W-1:0]    JITTER_MS_RST   = MS_W'(600);

    // Operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RESET   = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RETRY_COUNT   = 3'd0,
        CFG_MAX_WAIT_TIME     = 3'd1,
        CFG_RETRY_FACTOR_TIME = 3'd2,
        CFG_MIN_IDLE_TO_RESET = 3'd3,
        CFG_JITTER_MS         = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_INVALID   = 2'd2
    } status_code_t;

    typedef enum logic [1:0] {
        PH_NOT_STARTED = 2'd0,
        PH_IN_PROGRESS = 2'd1,
        PH_TERMINATED  = 2'd2
    } phase_t;

    // What the final beat does to state and result
    typedef enum logic [1:0] {
        RK_CLEAR   = 2'd0,
        RK_INVALID = 2'd1,
        RK_EXHAUST = 2'd2,
        RK_WAIT    = 2'd3
    } result_kind_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECIDE = 3'd1,
        S_START  = 3'd2,
        S_CALC   = 3'd3,
        S_MULT   = 3'd4,
        S_SUM    = 3'd5,
        S_EMIT   = 3'd6
    } ctrl_state_t;

    typedef struct packed {
        logic         load;
        logic         decide;
        logic         start;
        logic         step;
        logic         mult;
        logic         sum;
        logic         emit;
        result_kind_t kind;
    } ebt_cmd_t;

    typedef struct packed {
        logic op_reset;
        logic phase_bad;
        logic exhausted;
        logic pow_done;
        logic mod_done;
        logic out_free;
    } ebt_status_t;

endpackage

FILE: hw/rtl/ebt_if.sv
interface ebt_req_if;
    import ebt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [TIME_W-1:0]    current_time;
    logic [RND_W-1:0]     random_value;

    modport source (output valid, operation, current_time, random_value, input ready);
    modport sink   (input valid, operation, current_time, random_value, output ready);
endinterface

interface ebt_rsp_if;
    import ebt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TIME_W-1:0]    wait_time;
    logic [1:0]           result_status;
    logic [COUNT_W-1:0]   retries_done;

    modport source (output valid, wait_time, result_status, retries_done, input ready);
    modport sink   (input valid, wait_time, result_status, retries_done, output ready);
endinterface

interface ebt_cfg_if;
    import ebt_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ebt_ctrl.sv
module ebt_ctrl
    import ebt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  ebt_status_t stat,
    output ebt_cmd_t    cmd
);

    ctrl_state_t  state_reg, state_next;
    result_kind_t kind_reg, kind_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RK_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.kind   = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.op_reset)
                begin
                    kind_next  = RK_CLEAR;
                    state_next = S_EMIT;
                end
                else if (stat.phase_bad)
                begin
                    kind_next  = RK_INVALID;
                    state_next = S_EMIT;
                end
                else if (stat.exhausted)
                begin
                    kind_next  = RK_EXHAUST;
                    state_next = S_EMIT;
                end
                else
                begin
                    kind_next  = RK_WAIT;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.step = 1'b1;
                if (stat.pow_done && stat.mod_done)
                    state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ebt_datapath.sv
module ebt_datapath
    import ebt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ebt_cmd_t               cmd,
    output ebt_status_t            stat,
    // request payload
    input  logic                   operation,
    input  logic [TIME_W-1:0]      current_time,
    input  logic [RND_W-1:0]       random_value,
    // register writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // result beat
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [TIME_W-1:0]      wait_time,
    output logic [1:0]             result_status,
    output logic [COUNT_W-1:0]     retries_done
);

    // Configuration
    logic [COUNT_W-1:0] max_retry_reg;
    logic [TIME_W-1:0]  max_wait_reg;
    logic [TIME_W-1:0]  factor_reg;
    logic [TIME_W-1:0]  min_idle_reg;
    logic [MS_W-1:0]    jitter_ms_reg;

    // Retry state
    logic [COUNT_W-1:0] count_reg;
    logic [TIME_W-1:0]  prev_wait_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    phase_t             phase_reg;

    // Captured request
    logic               op_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               idle_reg;

    // Power unit
    logic [TIME_W-1:0]  p_reg;
    logic [COUNT_W-1:0] pow_left_reg;
    logic               pow_done_reg;

    // Modulo unit
    logic [MS_W-1:0]      rem_reg;
    logic [RND_W-1:0]     div_sh_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 mod_done_reg;

    logic [JITTER_W-1:0] jitter_reg;
    logic [TIME_W-1:0]   wait_reg;

    // Output stage
    logic               out_valid_reg;
    logic [TIME_W-1:0]  out_wait_reg;
    status_code_t       out_status_reg;
    logic [COUNT_W-1:0] out_retries_reg;

    logic [COUNT_W-1:0] count_inc;
    logic [TIME_W-1:0]  gap;
    logic               idle_now;
    logic [TIME_W-1:0]  eff_prev_wait;
    logic [COUNT_W-1:0] eff_count;
    logic [PROD_W-1:0]  p_mul;
    logic [MS_W:0]      trial;
    logic [TIME_W:0]    sum_full;

    assign stat.op_reset  = (op_reg == OP_RESET);
    assign stat.phase_bad = (phase_reg != PH_NOT_STARTED) && (phase_reg != PH_IN_PROGRESS);
    assign stat.exhausted = (max_retry_reg != '0) && (max_retry_reg <= count_reg);
    assign stat.pow_done  = pow_done_reg;
    assign stat.mod_done  = mod_done_reg;
    assign stat.out_free  = !out_valid_reg || rsp_ready;

    // Idle gap test and start values
    assign gap       = now_reg - prev_time_reg;
    assign idle_now  = (count_reg != '0) && (now_reg > prev_time_reg) && (gap > min_idle_reg);
    assign eff_prev_wait = idle_reg ? '0 : prev_wait_reg;
    assign eff_count     = idle_reg ? '0 : count_reg;
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);

    // One power step and one restoring division step
    assign p_mul = PROD_W'(p_reg) * PROD_W'(POWER_BASE);
    assign trial = {rem_reg, div_sh_reg[RND_W-1]};
    assign sum_full = {1'b0, p_reg} + (TIME_W+1)'(jitter_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retry_reg <= MAX_RETRY_RST;
            max_wait_reg  <= MAX_WAIT_RST;
            factor_reg    <= FACTOR_RST;
            min_idle_reg  <= MIN_IDLE_RST;
            jitter_ms_reg <= JITTER_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_RETRY_COUNT:   max_retry_reg <= cfg_data[COUNT_W-1:0];
                CFG_MAX_WAIT_TIME:     max_wait_reg  <= cfg_data[TIME_W-1:0];
                CFG_RETRY_FACTOR_TIME: factor_reg    <= cfg_data[TIME_W-1:0];
                CFG_MIN_IDLE_TO_RESET: min_idle_reg  <= cfg_data[TIME_W-1:0];
                CFG_JITTER_MS:         jitter_ms_reg <= cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // Retry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prev_wait_reg <= '0;
            prev_time_reg <= '0;
            phase_reg     <= PH_NOT_STARTED;
        end
        else if (cmd.start && idle_reg)
        begin
            count_reg     <= '0;
            prev_wait_reg <= '0;
            prev_time_reg <= '0;
        end
        else if (cmd.emit)
        begin
            case (cmd.kind)
                RK_CLEAR, RK_EXHAUST:
                begin
                    count_reg     <= '0;
                    prev_wait_reg <= '0;
                    prev_time_reg <= '0;
                    phase_reg     <= PH_NOT_STARTED;
                end
                RK_WAIT:
                begin
                    count_reg     <= count_inc;
                    prev_wait_reg <= wait_reg;
                    prev_time_reg <= now_reg;
                    phase_reg     <= PH_IN_PROGRESS;
                end
                default: ;
            endcase
        end
    end

    // Request capture and idle flag
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            now_reg    <= current_time;
            div_sh_reg <= random_value;
        end
        else if (cmd.step && !mod_done_reg)
            div_sh_reg <= {div_sh_reg[RND_W-2:0], 1'b0};
        if (cmd.decide)
            idle_reg <= idle_now;
    end

    // Power and modulo units
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg        <= '0;
            rem_reg      <= '0;
            pow_done_reg <= 1'b0;
            mod_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
            pow_left_reg <= '0;
        end
        else if (cmd.start)
        begin
            if (eff_prev_wait >= max_wait_reg)
            begin
                p_reg        <= max_wait_reg;
                pow_done_reg <= 1'b1;
            end
            else if (factor_reg > max_wait_reg)
            begin
                p_reg        <= max_wait_reg;
                pow_done_reg <= 1'b1;
            end
            else
            begin
                p_reg        <= factor_reg;
                pow_done_reg <= (eff_count == '0);
            end
            pow_left_reg <= eff_count;
            rem_reg      <= '0;
            div_cnt_reg  <= DIV_CNT_W'(RND_W - 1);
            mod_done_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (!pow_done_reg)
            begin
                if (p_reg == '0)
                    pow_done_reg <= 1'b1;
                else if (p_mul > PROD_W'(max_wait_reg))
                begin
                    p_reg        <= max_wait_reg;
                    pow_done_reg <= 1'b1;
                end
                else
                begin
                    p_reg        <= p_mul[TIME_W-1:0];
                    pow_left_reg <= pow_left_reg - COUNT_W'(1);
                    pow_done_reg <= (pow_left_reg == COUNT_W'(1));
                end
            end
            if (!mod_done_reg)
            begin
                if (trial >= {1'b0, jitter_ms_reg})
                    rem_reg <= MS_W'(trial - {1'b0, jitter_ms_reg});
                else
                    rem_reg <= trial[MS_W-1:0];
                if (div_cnt_reg == '0)
                    mod_done_reg <= 1'b1;
                else
                    div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

    // Jitter in ticks, then saturating sum
    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            if (jitter_ms_reg == '0)
                jitter_reg <= '0;
            else
                jitter_reg <= JITTER_W'(rem_reg) * JITTER_W'(TICKS_PER_MS);
        end
        if (cmd.sum)
            wait_reg <= sum_full[TIME_W] ? '1 : sum_full[TIME_W-1:0];
    end

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.kind)
                RK_INVALID:
                begin
                    out_wait_reg    <= '0;
                    out_status_reg  <= ST_INVALID;
                    out_retries_reg <= count_reg;
                end
                RK_EXHAUST:
                begin
                    out_wait_reg    <= '0;
                    out_status_reg  <= ST_EXHAUSTED;
                    out_retries_reg <= '0;
                end
                RK_WAIT:
                begin
                    out_wait_reg    <= wait_reg;
                    out_status_reg  <= ST_OK;
                    out_retries_reg <= count_inc;
                end
                default:
                begin
                    out_wait_reg    <= '0;
                    out_status_reg  <= ST_OK;
                    out_retries_reg <= '0;
                end
            endcase
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign wait_time     = out_wait_reg;
    assign result_status = out_status_reg;
    assign retries_done  = out_retries_reg;

endmodule

FILE: hw/rtl/exponential_backoff_timer.sv
// Exponential backoff timer with jitter. Each request beat gives one result
// beat. A reset operation, or a request that finds the retry limit reached,
// goes from the decision state straight to emitting its result beat. A wait
// request runs the doubling loop and a one-bit-per-cycle remainder unit side
// by side; the remainder needs 31 steps and the doubling loop one step per
// power, ending early once the cap is reached (at most 48 steps), and the
// controller moves on once both have finished. A result is emitted only
// while the result register is free or being read. The block works on one
// request at a time; the result sits in an output register so a new request
// can be taken while it waits. Register writes are always ready.
module exponential_backoff_timer
    import ebt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ebt_req_if.sink   req,
    ebt_rsp_if.source rsp,
    ebt_cfg_if.sink   cfg
);

    ebt_cmd_t    cmd;
    ebt_status_t stat;

    assign cfg.ready = 1'b1;

    ebt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ebt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (req.operation),
        .current_time  (req.current_time),
        .random_value  (req.random_value),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .wait_time     (rsp.wait_time),
        .result_status (rsp.result_status),
        .retries_done  (rsp.retries_done)
    );

endmodule
